// ===== sv/circ_pkg.sv =====
package circ_pkg;

  // limits and widths
  localparam int unsigned CHUNK_MAX    = 1024;
  localparam int unsigned IN_DATA_W    = 136;
  localparam int unsigned OUT_DATA_W   = 88;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned FIFO_DEPTH   = 4;
  localparam int unsigned FIFO_PTR_W   = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W   = $clog2(FIFO_DEPTH + 1);

  localparam logic [31:0] TIMEOUT_RESET   = 32'd60000;
  localparam logic [31:0] PARTITION_RESET = 32'd1048576;

  // command selector on the input tuser
  typedef enum logic [2:0] {
    FUNC_BEGIN = 3'd0,
    FUNC_DATA  = 3'd1,
    FUNC_END   = 3'd2,
    FUNC_ABORT = 3'd3,
    FUNC_TICK  = 3'd4
  } func_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMEOUT   = 1'd0,
    CFG_PARTITION = 1'd1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OP_BEGIN = 2'd0,
    OP_DATA  = 2'd1,
    OP_END   = 2'd2,
    OP_ABORT = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ERR  = 2'd1,
    ST_BUSY = 2'd2
  } code_t;

  typedef enum logic [4:0] {
    MSG_BEGIN_OK       = 5'd0,
    MSG_REBOOT_PENDING = 5'd1,
    MSG_ALREADY_ACTIVE = 5'd2,
    MSG_WRONG_PROJECT  = 5'd3,
    MSG_BAD_BEGIN      = 5'd4,
    MSG_NO_SLOT        = 5'd5,
    MSG_TOO_LARGE      = 5'd6,
    MSG_FLASH_BEGIN    = 5'd7,
    MSG_NOT_ACTIVE     = 5'd8,
    MSG_BAD_CHUNK      = 5'd9,
    MSG_DUP_CHUNK      = 5'd10,
    MSG_OFFSET_BAD     = 5'd11,
    MSG_FLASH_WRITE    = 5'd12,
    MSG_CHUNK_OK       = 5'd13,
    MSG_REBOOTING      = 5'd14,
    MSG_SIZE_MISMATCH  = 5'd15,
    MSG_FLASH_END      = 5'd16,
    MSG_SET_BOOT       = 5'd17,
    MSG_ABORTED        = 5'd18,
    MSG_TIMEOUT        = 5'd19
  } msg_t;

  // one status word
  typedef struct packed {
    op_t         op;
    code_t       code;
    logic [15:0] seq_echo;
    logic [31:0] done_bytes;
    logic [31:0] total_bytes;
    msg_t        message;
    logic        last;
  } res_t;

  function automatic res_t mk_res(op_t op, code_t code, logic [15:0] seq,
                                  logic [31:0] done, logic [31:0] total, msg_t msg);
    res_t r;
    r.op          = op;
    r.code        = code;
    r.seq_echo    = seq;
    r.done_bytes  = done;
    r.total_bytes = total;
    r.message     = msg;
    r.last        = 1'b0;
    return r;
  endfunction

endpackage

// ===== sv/chunked_image_receive_controller.sv =====
// path: a command word is registered in the input stage, then evaluated into the result
//   fifo once it has room for two status words; out_* offers the word at the fifo head
// throughput: one command word per cycle while the result fifo has room for two status
//   words; a command may yield two, so the one-word output port sets the sustained rate
// reset: synchronous active-low rst_n clears transfer state, reboot latch and fifo
//   pointers and reloads timeout_ticks = 60000 and partition_size = 1048576
module chunked_image_receive_controller (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // command channel
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // seq, image_bytes, max_chunk, offset, chunk_len, payload_bytes,
  // project_ok, flash_ok, boot_ok
  input  logic [circ_pkg::IN_DATA_W-1:0]        in_tdata,
  // func
  input  logic [2:0]                            in_tuser,
  // status channel
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // code, seq_echo, done_bytes, total_bytes, message
  output logic [circ_pkg::OUT_DATA_W-1:0]       out_tdata,
  // op
  output logic [1:0]                            out_tuser,
  output logic                                  out_tlast,
  // configuration write channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [circ_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [31:0]                           cfg_data
);

  // configuration registers
  logic [31:0] timeout_ticks_r;
  logic [31:0] partition_size_r;

  // transfer state
  logic        active_r,         active_nxt;
  logic [31:0] expected_size_r,  expected_size_nxt;
  logic [31:0] written_bytes_r,  written_bytes_nxt;
  logic [15:0] last_seq_r,       last_seq_nxt;
  logic [31:0] idle_ticks_r,     idle_ticks_nxt;
  logic        reboot_pending_r, reboot_pending_nxt;
  logic [15:0] reboot_seq_r,     reboot_seq_nxt;
  logic [31:0] reboot_total_r,   reboot_total_nxt;

  // input register
  logic                           stage_valid_r;
  logic [circ_pkg::IN_DATA_W-1:0] stage_data_r;
  logic [2:0]                     stage_func_r;
  logic                           stage_fire;
  logic                           in_accept;

  // unpacked command fields
  circ_pkg::func_t func;
  logic [15:0] seq;
  logic [31:0] isz;
  logic [15:0] csz;
  logic [31:0] off;
  logic [15:0] clen;
  logic [15:0] pay;
  logic        proj_ok;
  logic        flash_ok;
  logic        boot_ok;

  // command evaluation
  logic [31:0] idle_pre;
  logic        chk;
  logic        stale;
  logic        has_main;
  logic [32:0] end_sum;
  circ_pkg::res_t abort_res;
  circ_pkg::res_t main_res;
  circ_pkg::res_t push0;
  circ_pkg::res_t push1;
  logic [1:0]  push_n;

  // result fifo
  circ_pkg::res_t fifo_mem [circ_pkg::FIFO_DEPTH];
  logic [circ_pkg::FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [circ_pkg::FIFO_CNT_W-1:0] count_r;
  logic                            pop;
  circ_pkg::res_t                  head;

  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_ticks_r  <= circ_pkg::TIMEOUT_RESET;
      partition_size_r <= circ_pkg::PARTITION_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (circ_pkg::cfg_idx_t'(cfg_index))
        circ_pkg::CFG_TIMEOUT:   timeout_ticks_r  <= cfg_data;
        circ_pkg::CFG_PARTITION: partition_size_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // input stage handshake: evaluate only with room for two status words
  assign stage_fire = stage_valid_r &&
                      (count_r <= circ_pkg::FIFO_CNT_W'(circ_pkg::FIFO_DEPTH - 2));
  assign in_tready  = !stage_valid_r || stage_fire;
  assign in_accept  = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (in_accept) begin
      stage_valid_r <= 1'b1;
    end else if (stage_fire) begin
      stage_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      stage_data_r <= in_tdata;
      stage_func_r <= in_tuser;
    end
  end

  // field unpack
  assign func     = circ_pkg::func_t'(stage_func_r);
  assign seq      = stage_data_r[15:0];
  assign isz      = stage_data_r[47:16];
  assign csz      = stage_data_r[63:48];
  assign off      = stage_data_r[95:64];
  assign clen     = stage_data_r[111:96];
  assign pay      = stage_data_r[127:112];
  assign proj_ok  = stage_data_r[128];
  assign flash_ok = stage_data_r[129];
  assign boot_ok  = stage_data_r[130];

  // idle count after a tick, saturating
  always_comb begin
    idle_pre = idle_ticks_r;
    if (func == circ_pkg::FUNC_TICK && active_r && idle_ticks_r != '1) begin
      idle_pre = idle_ticks_r + 32'd1;
    end
  end

  // which commands look at staleness first
  always_comb begin
    case (func)
      circ_pkg::FUNC_BEGIN: chk = !reboot_pending_r;
      circ_pkg::FUNC_DATA:  chk = 1'b1;
      circ_pkg::FUNC_END:   chk = !(reboot_pending_r && seq == reboot_seq_r &&
                                    isz == reboot_total_r);
      circ_pkg::FUNC_TICK:  chk = 1'b1;
      default:              chk = 1'b0;
    endcase
  end

  assign stale   = chk && active_r && (idle_pre > timeout_ticks_r);
  assign end_sum = {1'b0, off} + {17'b0, clen};

  assign abort_res = circ_pkg::mk_res(circ_pkg::OP_ABORT, circ_pkg::ST_ERR, last_seq_r,
                                      written_bytes_r, expected_size_r,
                                      circ_pkg::MSG_TIMEOUT);

  // command evaluation and next state
  always_comb begin
    active_nxt         = active_r;
    expected_size_nxt  = expected_size_r;
    written_bytes_nxt  = written_bytes_r;
    last_seq_nxt       = last_seq_r;
    idle_ticks_nxt     = idle_pre;
    reboot_pending_nxt = reboot_pending_r;
    reboot_seq_nxt     = reboot_seq_r;
    reboot_total_nxt   = reboot_total_r;
    has_main           = 1'b1;
    main_res           = circ_pkg::mk_res(circ_pkg::OP_ABORT, circ_pkg::ST_OK, seq,
                                          32'd0, 32'd0, circ_pkg::MSG_ABORTED);

    // stale transfer is dropped before the command itself
    if (stale) begin
      active_nxt        = 1'b0;
      expected_size_nxt = '0;
      written_bytes_nxt = '0;
      last_seq_nxt      = '0;
      idle_ticks_nxt    = '0;
    end

    case (func)
      circ_pkg::FUNC_BEGIN: begin
        if (reboot_pending_r) begin
          main_res = circ_pkg::mk_res(circ_pkg::OP_BEGIN, circ_pkg::ST_BUSY, seq,
                       reboot_total_r, reboot_total_r, circ_pkg::MSG_REBOOT_PENDING);
        end else if (active_nxt) begin
          if (seq == last_seq_nxt && written_bytes_nxt == '0 &&
              isz == expected_size_nxt) begin
            // repeated begin
            idle_ticks_nxt = '0;
            main_res = circ_pkg::mk_res(circ_pkg::OP_BEGIN, circ_pkg::ST_OK, seq,
                         32'd0, expected_size_nxt, circ_pkg::MSG_BEGIN_OK);
          end else begin
            main_res = circ_pkg::mk_res(circ_pkg::OP_BEGIN, circ_pkg::ST_BUSY, seq,
                         written_bytes_nxt, expected_size_nxt,
                         circ_pkg::MSG_ALREADY_ACTIVE);
          end
        end else if (!proj_ok) begin
          main_res = circ_pkg::mk_res(circ_pkg::OP_BEGIN, circ_pkg::ST_ERR, seq,
                       32'd0, isz, circ_pkg::MSG_WRONG_PROJECT);
        end else if (csz == '0 || csz > 16'(circ_pkg::CHUNK_MAX) || isz == '0) begin
          main_res = circ_pkg::mk_res(circ_pkg::OP_BEGIN, circ_pkg::ST_ERR, seq,
                       32'd0, isz, circ_pkg::MSG_BAD_BEGIN);
        end else if (partition_size_r == '0) begin
          main_res = circ_pkg::mk_res(circ_pkg::OP_BEGIN, circ_pkg::ST_ERR, seq,
                       32'd0, isz, circ_pkg::MSG_NO_SLOT);
        end else if (isz > partition_size_r) begin
          main_res = circ_pkg::mk_res(circ_pkg::OP_BEGIN, circ_pkg::ST_ERR, seq,
                       32'd0, isz, circ_pkg::MSG_TOO_LARGE);
        end else if (!flash_ok) begin
          main_res = circ_pkg::mk_res(circ_pkg::OP_BEGIN, circ_pkg::ST_ERR, seq,
                       32'd0, isz, circ_pkg::MSG_FLASH_BEGIN);
        end else begin
          // open a new transfer
          active_nxt        = 1'b1;
          expected_size_nxt = isz;
          written_bytes_nxt = '0;
          last_seq_nxt      = seq;
          idle_ticks_nxt    = '0;
          main_res = circ_pkg::mk_res(circ_pkg::OP_BEGIN, circ_pkg::ST_OK, seq,
                       32'd0, isz, circ_pkg::MSG_BEGIN_OK);
        end
      end

      circ_pkg::FUNC_DATA: begin
        if (!active_nxt) begin
          main_res = circ_pkg::mk_res(circ_pkg::OP_DATA, circ_pkg::ST_ERR, seq,
                       32'd0, 32'd0, circ_pkg::MSG_NOT_ACTIVE);
        end else if (clen == '0 || clen > 16'(circ_pkg::CHUNK_MAX) || pay < clen) begin
          main_res = circ_pkg::mk_res(circ_pkg::OP_DATA, circ_pkg::ST_ERR, seq,
                       written_bytes_nxt, expected_size_nxt, circ_pkg::MSG_BAD_CHUNK);
        end else if (off != written_bytes_nxt || end_sum > {1'b0, expected_size_nxt}) begin
          if (seq == last_seq_nxt && off < written_bytes_nxt &&
              end_sum == {1'b0, written_bytes_nxt}) begin
            // repeated chunk
            idle_ticks_nxt = '0;
            main_res = circ_pkg::mk_res(circ_pkg::OP_DATA, circ_pkg::ST_OK, seq,
                         written_bytes_nxt, expected_size_nxt, circ_pkg::MSG_DUP_CHUNK);
          end else begin
            main_res = circ_pkg::mk_res(circ_pkg::OP_DATA, circ_pkg::ST_ERR, seq,
                         written_bytes_nxt, expected_size_nxt, circ_pkg::MSG_OFFSET_BAD);
          end
        end else if (!flash_ok) begin
          main_res = circ_pkg::mk_res(circ_pkg::OP_DATA, circ_pkg::ST_ERR, seq,
                       written_bytes_nxt, expected_size_nxt, circ_pkg::MSG_FLASH_WRITE);
          active_nxt        = 1'b0;
          expected_size_nxt = '0;
          written_bytes_nxt = '0;
          last_seq_nxt      = '0;
          idle_ticks_nxt    = '0;
        end else begin
          written_bytes_nxt = end_sum[31:0];
          last_seq_nxt      = seq;
          idle_ticks_nxt    = '0;
          main_res = circ_pkg::mk_res(circ_pkg::OP_DATA, circ_pkg::ST_OK, seq,
                       end_sum[31:0], expected_size_nxt, circ_pkg::MSG_CHUNK_OK);
        end
      end

      circ_pkg::FUNC_END: begin
        if (!chk) begin
          // repeated end after a finished transfer
          main_res = circ_pkg::mk_res(circ_pkg::OP_END, circ_pkg::ST_OK, seq,
                       reboot_total_r, reboot_total_r, circ_pkg::MSG_REBOOTING);
        end else if (!active_nxt) begin
          main_res = circ_pkg::mk_res(circ_pkg::OP_END, circ_pkg::ST_ERR, seq,
                       32'd0, 32'd0, circ_pkg::MSG_NOT_ACTIVE);
        end else begin
          if (isz != expected_size_nxt || written_bytes_nxt != expected_size_nxt) begin
            main_res = circ_pkg::mk_res(circ_pkg::OP_END, circ_pkg::ST_ERR, seq,
                         written_bytes_nxt, expected_size_nxt,
                         circ_pkg::MSG_SIZE_MISMATCH);
          end else if (!flash_ok) begin
            main_res = circ_pkg::mk_res(circ_pkg::OP_END, circ_pkg::ST_ERR, seq,
                         written_bytes_nxt, expected_size_nxt, circ_pkg::MSG_FLASH_END);
          end else if (!boot_ok) begin
            main_res = circ_pkg::mk_res(circ_pkg::OP_END, circ_pkg::ST_ERR, seq,
                         written_bytes_nxt, expected_size_nxt, circ_pkg::MSG_SET_BOOT);
          end else begin
            reboot_pending_nxt = 1'b1;
            reboot_seq_nxt     = seq;
            reboot_total_nxt   = expected_size_nxt;
            main_res = circ_pkg::mk_res(circ_pkg::OP_END, circ_pkg::ST_OK, seq,
                         written_bytes_nxt, expected_size_nxt, circ_pkg::MSG_REBOOTING);
          end
          // every outcome here closes the transfer
          active_nxt        = 1'b0;
          expected_size_nxt = '0;
          written_bytes_nxt = '0;
          last_seq_nxt      = '0;
          idle_ticks_nxt    = '0;
        end
      end

      circ_pkg::FUNC_ABORT: begin
        if (reboot_pending_r) begin
          main_res = circ_pkg::mk_res(circ_pkg::OP_ABORT, circ_pkg::ST_BUSY, seq,
                       reboot_total_r, reboot_total_r, circ_pkg::MSG_REBOOT_PENDING);
        end else begin
          active_nxt        = 1'b0;
          expected_size_nxt = '0;
          written_bytes_nxt = '0;
          last_seq_nxt      = '0;
          idle_ticks_nxt    = '0;
          main_res = circ_pkg::mk_res(circ_pkg::OP_ABORT, circ_pkg::ST_OK, seq,
                       32'd0, 32'd0, circ_pkg::MSG_ABORTED);
        end
      end

      circ_pkg::FUNC_TICK: has_main = 1'b0;

      default: has_main = 1'b0;
    endcase
  end

  // order the status words and mark the final one
  always_comb begin
    push0      = abort_res;
    push1      = main_res;
    push1.last = 1'b1;
    push_n     = {1'b0, stale} + {1'b0, has_main};
    if (!stale) begin
      push0 = main_res;
    end
    if (push_n == 2'd1) begin
      push0.last = 1'b1;
    end
    if (!stage_fire) begin
      push_n = 2'd0;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r         <= 1'b0;
      expected_size_r  <= '0;
      written_bytes_r  <= '0;
      last_seq_r       <= '0;
      idle_ticks_r     <= '0;
      reboot_pending_r <= 1'b0;
      reboot_seq_r     <= '0;
      reboot_total_r   <= '0;
    end else if (stage_fire) begin
      active_r         <= active_nxt;
      expected_size_r  <= expected_size_nxt;
      written_bytes_r  <= written_bytes_nxt;
      last_seq_r       <= last_seq_nxt;
      idle_ticks_r     <= idle_ticks_nxt;
      reboot_pending_r <= reboot_pending_nxt;
      reboot_seq_r     <= reboot_seq_nxt;
      reboot_total_r   <= reboot_total_nxt;
    end
  end

  // result fifo storage
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      fifo_mem[wr_ptr_r] <= push0;
    end
    if (push_n == 2'd2) begin
      fifo_mem[wr_ptr_r + circ_pkg::FIFO_PTR_W'(1)] <= push1;
    end
  end

  // result fifo pointers
  assign pop = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + circ_pkg::FIFO_PTR_W'(push_n);
      rd_ptr_r <= rd_ptr_r + circ_pkg::FIFO_PTR_W'(pop);
      count_r  <= count_r + circ_pkg::FIFO_CNT_W'(push_n)
                          - circ_pkg::FIFO_CNT_W'(pop);
    end
  end

  // output word
  assign head       = fifo_mem[rd_ptr_r];
  assign out_tvalid = (count_r != '0);
  assign out_tdata  = {1'b0, head.message, head.total_bytes, head.done_bytes,
                       head.seq_echo, head.code};
  assign out_tuser  = head.op;
  assign out_tlast  = head.last;

`ifndef NO_ASSERTIONS
  // fifo never overfills
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= circ_pkg::FIFO_CNT_W'(circ_pkg::FIFO_DEPTH))
    else $error("result fifo overflow");

  // reboot latch holds until reset
  a_reboot_hold: assert property (@(posedge clk) disable iff (!rst_n)
    reboot_pending_r |=> reboot_pending_r)
    else $error("reboot latch dropped");

  // an idle transfer carries no leftover counters
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !active_r |-> (written_bytes_r == '0 && expected_size_r == '0 &&
                   idle_ticks_r == '0))
    else $error("inactive transfer has stale counters");

  // a tick never produces more than the timeout abort
  a_tick_single: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_fire && func == circ_pkg::FUNC_TICK) |-> (push_n != 2'd2))
    else $error("tick produced two status words");
`endif

endmodule
